>>> sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check clocked on clk, switched off while rst is high.
`define CPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("closest point pair check failed");

// Check clocked on clk that also holds across reset.
`define CPD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("closest point pair reset check failed");

`endif

>>> sv/cpd_pkg.sv
// Package: widths, op codes and defaults for the closest point pair block.
package cpd_pkg;

  localparam int DEF_REF_DEPTH  = 1024;
  localparam int DEF_COORD_BITS = 10;

  localparam int OP_W       = 2;
  localparam int TOL_W      = 10;
  localparam int SQ_OUT_W   = 21;
  localparam int ROOT_OUT_W = 11;
  localparam int IDX_OUT_W  = 10;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_PROBE  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  // register index, taken from paddr above the byte offset
  localparam logic REG_TOL = 1'b0;

  localparam logic [TOL_W-1:0] TOL_RESET = 10'd30;

endpackage

>>> sv/cpd_if.sv
// Channel interfaces: command items in, report items out.
interface cpd_cmd_if import cpd_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;

  modport source (output valid, op, coord_x, coord_y, input ready);
  modport sink   (input valid, op, coord_x, coord_y, output ready);
endinterface

interface cpd_rpt_if import cpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SQ_OUT_W-1:0]   min_sq_distance;
  logic [ROOT_OUT_W-1:0] min_distance_root;
  logic [IDX_OUT_W-1:0]  nearest_index;
  logic                  found;
  logic                  is_neighbour;
  logic                  overflow;

  modport source (output valid, min_sq_distance, min_distance_root, nearest_index,
                  found, is_neighbour, overflow, input ready);
  modport sink   (input valid, min_sq_distance, min_distance_root, nearest_index,
                  found, is_neighbour, overflow, output ready);
endinterface

>>> sv/closest_point_pair_distance.sv
// Top level: brute-force closest pair search between stored and probe points.
//
//  channel  | dir | transfer carries
//  ---------+-----+-----------------------------------------------------------
//  cmd      | in  | op, coord_x, coord_y (load / probe / report)
//  rpt      | out | min_sq_distance, min_distance_root, nearest_index, flags
//  apb      | in  | neighbour_tolerance at byte address 0
//
//  Probe: one stored point per cycle through the single read port of the point store
//  and one distance unit, then the pipeline drains. Report: one root bit per cycle
//  when something was compared, none otherwise; it also waits while an earlier
//  report is unread.
//  cmd.ready is low while a probe or report is in progress.
//  Reset (rst, synchronous) clears control state and sets tolerance to 30;
//  the store itself needs no clearing, only entries below ref_count are read.
module closest_point_pair_distance import cpd_pkg::*; #(
  parameter int REF_DEPTH  = DEF_REF_DEPTH,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  cpd_cmd_if.sink               cmd,
  cpd_rpt_if.source             rpt,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W     = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(REF_DEPTH + 1);
  localparam int PT_W      = 2 * COORD_BITS;
  localparam int SQ_W      = 2 * COORD_BITS + 1;
  localparam int ROOT_W    = COORD_BITS + 1;
  localparam int RB_W      = $clog2(ROOT_W);
  localparam int SQ_CMP_W  = (SQ_W > SQ_OUT_W) ? SQ_W : SQ_OUT_W;
  localparam int RT_CMP_W  = (ROOT_W > ROOT_OUT_W) ? ROOT_W : ROOT_OUT_W;
  localparam int TOLSQ_W   = 2 * TOL_W;
  localparam int NB_CMP_W  = (SQ_W > TOLSQ_W) ? SQ_W : TOLSQ_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PROBE  = 4'b0010,
    S_ROOT   = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t state;

  // configuration
  logic [TOL_W-1:0] tol;
  logic             cfg_wr;

  // accumulated search state
  logic [CNT_W-1:0] ref_count;
  logic [SQ_W-1:0]  best_sq;
  logic [IDX_W-1:0] best_index;
  logic             any_compared;
  logic             load_dropped;

  // probe point and compare pipeline
  logic [COORD_BITS-1:0] px, py;
  logic [CNT_W-1:0]      issue_cnt;
  logic                  rd_en;
  logic [PT_W-1:0]       rd_data;
  logic                  v1, v2;
  logic [IDX_W-1:0]      idx1, idx2;
  logic [COORD_BITS-1:0] rx, ry, dx, dy;
  logic [PT_W-1:0]       sqx, sqy;
  logic [SQ_W-1:0]       cand_sq;
  logic                  better;

  // square root unit
  logic [ROOT_W-1:0]   root;
  logic [RB_W-1:0]     rbit;
  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] trial_sq;

  // report
  logic                  cmd_fire;
  logic                  rpt_valid;
  logic                  rpt_load;
  logic                  store_full;
  logic [TOLSQ_W-1:0]    tol_sq;
  logic                  near;
  logic [SQ_OUT_W-1:0]   sq_sat;
  logic [ROOT_OUT_W-1:0] root_sat;

  logic [PT_W-1:0] ref_mem [REF_DEPTH];

  // ---------------------------------------------------------------------
  // APB register: writes complete in the access phase, no wait states
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[APB_ADDR_W-1] == REG_TOL) ? APB_DATA_W'(tol) : '0;

  assign cmd_fire   = cmd.valid && cmd.ready;
  assign cmd.ready  = (state == S_IDLE);
  assign store_full = (ref_count >= CNT_W'(REF_DEPTH));

  // ---------------------------------------------------------------------
  // Point store: one write port for loads, one registered read for probes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.op == OP_LOAD && !store_full) begin
      ref_mem[ref_count[IDX_W-1:0]] <= {cmd.coord_x, cmd.coord_y};
    end
  end

  assign rd_en = (state == S_PROBE) && (issue_cnt < ref_count);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ref_mem[issue_cnt[IDX_W-1:0]];
    end
  end

  // ---------------------------------------------------------------------
  // Distance unit: stage 2 squares the differences, stage 3 adds and
  // compares against the running best. Strict less-than keeps the first
  // minimum, and points come out in store order.
  // ---------------------------------------------------------------------
  assign rx = rd_data[PT_W-1:COORD_BITS];
  assign ry = rd_data[COORD_BITS-1:0];
  assign dx = (px > rx) ? (px - rx) : (rx - px);
  assign dy = (py > ry) ? (py - ry) : (ry - py);

  assign cand_sq = SQ_W'(sqx) + SQ_W'(sqy);
  assign better  = !any_compared || (cand_sq < best_sq);

  // Floor square root, one bit per cycle from the top
  assign trial    = root | (ROOT_W'(1) << rbit);
  assign trial_sq = trial * trial;

  // Report fields, saturated where the field is narrower than the value
  assign tol_sq   = tol * tol;
  assign near     = NB_CMP_W'(best_sq) < NB_CMP_W'(tol_sq);
  assign sq_sat   = (SQ_CMP_W'(best_sq) > SQ_CMP_W'({SQ_OUT_W{1'b1}})) ?
                    {SQ_OUT_W{1'b1}} : SQ_OUT_W'(best_sq);
  assign root_sat = (RT_CMP_W'(root) > RT_CMP_W'({ROOT_OUT_W{1'b1}})) ?
                    {ROOT_OUT_W{1'b1}} : ROOT_OUT_W'(root);

  assign rpt_load  = (state == S_REPORT) && (!rpt_valid || rpt.ready);
  assign rpt.valid = rpt_valid;

  // ---------------------------------------------------------------------
  // Payload registers (no reset)
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      px <= cmd.coord_x;
      py <= cmd.coord_y;
    end
    idx1 <= issue_cnt[IDX_W-1:0];
    idx2 <= idx1;
    sqx  <= dx * dx;
    sqy  <= dy * dy;
    if (rpt_load) begin
      if (any_compared) begin
        rpt.min_sq_distance   <= sq_sat;
        rpt.min_distance_root <= root_sat;
        rpt.nearest_index     <= IDX_OUT_W'(best_index);
        rpt.found             <= 1'b1;
        rpt.is_neighbour      <= near;
      end else begin
        rpt.min_sq_distance   <= {SQ_OUT_W{1'b1}};
        rpt.min_distance_root <= '0;
        rpt.nearest_index     <= '0;
        rpt.found             <= 1'b0;
        rpt.is_neighbour      <= 1'b0;
      end
      rpt.overflow <= load_dropped;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and control state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tol          <= TOL_RESET;
      ref_count    <= '0;
      best_sq      <= '1;
      best_index   <= '0;
      any_compared <= 1'b0;
      load_dropped <= 1'b0;
      issue_cnt    <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      root         <= '0;
      rbit         <= '0;
      rpt_valid    <= 1'b0;
    end else begin
      if (cfg_wr && paddr[APB_ADDR_W-1] == REG_TOL) begin
        tol <= pwdata[TOL_W-1:0];
      end

      // a new report may replace one taken in the same cycle
      if (rpt_load) begin
        rpt_valid <= 1'b1;
      end else if (rpt_valid && rpt.ready) begin
        rpt_valid <= 1'b0;
      end

      v1 <= rd_en;
      v2 <= v1;
      if (rd_en) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (v2 && better) begin
        best_sq      <= cand_sq;
        best_index   <= idx2;
        any_compared <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            if (cmd.op == OP_LOAD) begin
              if (!store_full) begin
                ref_count <= ref_count + CNT_W'(1);
              end else begin
                load_dropped <= 1'b1;
              end
            end else if (cmd.op == OP_PROBE) begin
              issue_cnt <= '0;
              state     <= S_PROBE;
            end else if (cmd.op == OP_REPORT) begin
              root <= '0;
              rbit <= RB_W'(ROOT_W - 1);
              state <= any_compared ? S_ROOT : S_REPORT;
            end
          end
        end
        S_PROBE: begin
          // all points issued and the pipeline drained
          if (!rd_en && !v1 && !v2) begin
            state <= S_IDLE;
          end
        end
        S_ROOT: begin
          if ((2*ROOT_W)'(best_sq) >= trial_sq) begin
            root <= trial;
          end
          if (rbit == '0) begin
            state <= S_REPORT;
          end else begin
            rbit <= rbit - RB_W'(1);
          end
        end
        S_REPORT: begin
          if (rpt_load) begin
            ref_count    <= '0;
            best_sq      <= '1;
            best_index   <= '0;
            any_compared <= 1'b0;
            load_dropped <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/cpd_checker.sv
// Port-level checker for the closest point pair block, bound to the top level.
`include "assert_macros.svh"

module cpd_checker import cpd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_ready,
  input logic [OP_W-1:0]       cmd_op,
  input logic                  rpt_valid,
  input logic                  rpt_ready,
  input logic [SQ_OUT_W-1:0]   rpt_min_sq_distance,
  input logic [ROOT_OUT_W-1:0] rpt_min_distance_root,
  input logic [IDX_OUT_W-1:0]  rpt_nearest_index,
  input logic                  rpt_found,
  input logic                  rpt_is_neighbour
);

  // a waiting report is held until taken
  `CPD_ASSERT(a_rpt_hold, ((rpt_valid && !rpt_ready) |=> (rpt_valid && $stable(rpt_min_sq_distance) && $stable(rpt_nearest_index))))

  // probe and report both take the block away from the command channel
  `CPD_ASSERT(a_busy_after_work, ((cmd_valid && cmd_ready && (cmd_op == OP_PROBE || cmd_op == OP_REPORT)) |=> !cmd_ready))

  // an empty report carries the fixed pattern
  `CPD_ASSERT(a_empty_report, ((rpt_valid && !rpt_found) |-> (rpt_min_sq_distance == '1 && rpt_min_distance_root == '0 && rpt_nearest_index == '0)))

  // a neighbour needs a comparison behind it
  `CPD_ASSERT(a_neighbour_found, ((rpt_valid && rpt_is_neighbour) |-> rpt_found))

  // nothing is offered straight after reset
  `CPD_ASSERT_RST(a_reset_quiet, (rst |=> !rpt_valid))

endmodule

bind closest_point_pair_distance cpd_checker u_cpd_checker (
  .clk                   (clk),
  .rst                   (rst),
  .cmd_valid             (cmd.valid),
  .cmd_ready             (cmd.ready),
  .cmd_op                (cmd.op),
  .rpt_valid             (rpt.valid),
  .rpt_ready             (rpt.ready),
  .rpt_min_sq_distance   (rpt.min_sq_distance),
  .rpt_min_distance_root (rpt.min_distance_root),
  .rpt_nearest_index     (rpt.nearest_index),
  .rpt_found             (rpt.found),
  .rpt_is_neighbour      (rpt.is_neighbour)
);

>>> tb/closest_point_pair_distance_tb.sv
// Testbench: closest point pair block driven with load/probe/report transfers, reports checked.
module closest_point_pair_distance_tb;
  import cpd_pkg::*;

  localparam int CW            = DEF_COORD_BITS;
  localparam int BEST_W        = SQ_OUT_W + 1;      // running minimum, one bit above the field
  localparam int STALL_LIMIT   = 6000;              // watchdog limit, well above a full-store probe
  localparam int SETTLE_CYCLES = DEF_COORD_BITS + 12;

  // op value 3 is not decoded; the block must swallow it
  localparam logic [OP_W-1:0]     OP_IGNORED = 2'd3;
  localparam logic [SQ_OUT_W-1:0] SQ_NONE    = '1;

  // field order matches the report channel, so a concatenation fills it
  typedef struct packed {
    logic [SQ_OUT_W-1:0]   sq;
    logic [ROOT_OUT_W-1:0] root;
    logic [IDX_OUT_W-1:0]  idx;
    logic                  found;
    logic                  neighbour;
    logic                  overflow;
  } pair_report_t;

  // Tracks stored points and the running minimum; queues the report each
  // accepted report command should produce and checks the block against it.
  class nearest_pair_tracker;
    bit [CW-1:0]        ref_x [DEF_REF_DEPTH];
    bit [CW-1:0]        ref_y [DEF_REF_DEPTH];
    int unsigned        stored;
    bit [BEST_W-1:0]    best_sq;
    bit [IDX_OUT_W-1:0] best_idx;
    bit                 compared;
    bit                 dropped;
    bit [TOL_W-1:0]     tolerance;
    pair_report_t       awaited[$];
    int unsigned        mismatches;

    function new();
      clear_search();
      tolerance  = TOL_RESET;
      mismatches = 0;
    endfunction

    function void clear_search();
      stored   = 0;
      best_sq  = '1;
      best_idx = '0;
      compared = 1'b0;
      dropped  = 1'b0;
    endfunction

    static function bit [ROOT_OUT_W-1:0] floor_root(bit [BEST_W-1:0] v);
      bit [BEST_W-1:0] r;
      bit [BEST_W-1:0] t;
      r = '0;
      for (int b = ROOT_OUT_W - 1; b >= 0; b--) begin
        t = r | (BEST_W'(1) << b);
        if (t * t <= v) r = t;
      end
      return r[ROOT_OUT_W-1:0];
    endfunction

    function void note_command(bit [OP_W-1:0] op, bit [CW-1:0] x, bit [CW-1:0] y);
      bit [CW-1:0]     dx;
      bit [CW-1:0]     dy;
      bit [BEST_W-1:0] d;
      bit [BEST_W-1:0] tol_sq;
      pair_report_t    r;
      case (op)
        OP_LOAD: begin
          if (stored < DEF_REF_DEPTH) begin
            ref_x[stored] = x;
            ref_y[stored] = y;
            stored++;
          end else begin
            dropped = 1'b1;
          end
        end
        OP_PROBE: begin
          // store order; strict less-than keeps the first minimum
          for (int j = 0; j < stored; j++) begin
            dx = (x > ref_x[j]) ? x - ref_x[j] : ref_x[j] - x;
            dy = (y > ref_y[j]) ? y - ref_y[j] : ref_y[j] - y;
            d  = dx * dx + dy * dy;
            if (!compared || d < best_sq) begin
              best_sq  = d;
              best_idx = j[IDX_OUT_W-1:0];
              compared = 1'b1;
            end
          end
        end
        OP_REPORT: begin
          tol_sq = tolerance * tolerance;
          if (compared) begin
            r.sq        = (best_sq > BEST_W'(SQ_NONE)) ? SQ_NONE : best_sq[SQ_OUT_W-1:0];
            r.root      = floor_root(best_sq);
            r.idx       = best_idx;
            r.found     = 1'b1;
            r.neighbour = (best_sq < tol_sq);
          end else begin
            r.sq        = SQ_NONE;
            r.root      = '0;
            r.idx       = '0;
            r.found     = 1'b0;
            r.neighbour = 1'b0;
          end
          r.overflow = dropped;
          awaited = {awaited, r};
          clear_search();
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: report %s expected %0d got %0d", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(pair_report_t got);
      pair_report_t want;
      if (awaited.size() == 0) begin
        $display("%0t: report expected none got sq %0d idx %0d", $time, got.sq, got.idx);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("min_sq_distance",   want.sq,        got.sq);
      compare_field("min_distance_root", want.root,      got.root);
      compare_field("nearest_index",     want.idx,       got.idx);
      compare_field("found",             want.found,     got.found);
      compare_field("is_neighbour",      want.neighbour, got.neighbour);
      compare_field("overflow",          want.overflow,  got.overflow);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cpd_cmd_if #(.COORD_BITS(CW)) cmd_ch ();
  cpd_rpt_if                    rpt_ch ();

  nearest_pair_tracker tracker;
  bit                  calm = 1'b0;         // no idling on either side while set
  int unsigned         stall_cycles = 0;

  closest_point_pair_distance u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rpt     (rpt_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Report side back-pressure: ready low about 35 percent of the time, never while calm is set.
  always @(posedge clk) begin
    rpt_ch.ready <= calm || ($urandom_range(99) >= 35);
  end

  // Fields are sampled straight after the edge, so they hold pre-edge values.
  always @(posedge clk) begin
    if (!rst && rpt_ch.valid && rpt_ch.ready)
      tracker.check_report({rpt_ch.min_sq_distance, rpt_ch.min_distance_root,
                            rpt_ch.nearest_index, rpt_ch.found,
                            rpt_ch.is_neighbour, rpt_ch.overflow});
  end

  // Watchdog: counts cycles without any transfer or register write.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rpt_ch.valid && rpt_ch.ready) ||
        (psel && penable && pready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("closest_point_pair_distance verification failed");
    $finish;
  end

  // One command transfer, then an optional random gap. With no gap, valid
  // stays high and the caller supplies the next item in the same step.
  task automatic send_cmd(logic [OP_W-1:0] op, logic [CW-1:0] x, logic [CW-1:0] y);
    int gap;
    cmd_ch.valid   <= 1'b1;
    cmd_ch.op      <= op;
    cmd_ch.coord_x <= x;
    cmd_ch.coord_y <= y;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    tracker.note_command(op, x, y);
    gap = (calm || $urandom_range(99) >= 35) ? 0 : $urandom_range(1, 4);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Block goes idle: every report back, then SETTLE_CYCLES of margin for a trailing
  // load or probe (only ever after a report here, so the store is empty).
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_tolerance(logic [TOL_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TOL, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.tolerance = value;
  endtask

  function automatic logic [CW-1:0] pick_coord(int centre, int spread);
    int v;
    v = centre + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > (1 << CW) - 1) v = (1 << CW) - 1;
    return v[CW-1:0];
  endfunction

  // One scene: loads around a centre (clustered or spread) with the odd ignored
  // op, probes with the odd late load or early report mixed in, closing report.
  task automatic run_session(int max_loads);
    int cx;
    int cy;
    int spread;
    cx     = $urandom_range(0, (1 << CW) - 1);
    cy     = $urandom_range(0, (1 << CW) - 1);
    spread = ($urandom_range(99) < 50) ? $urandom_range(0, 40) : (1 << CW);
    if ($urandom_range(99) < 8)
      send_cmd(OP_PROBE, pick_coord(cx, spread), pick_coord(cy, spread));
    repeat ($urandom_range(1, max_loads)) begin
      if ($urandom_range(99) < 5)
        send_cmd(OP_IGNORED, CW'($urandom_range(0, (1 << CW) - 1)),
                 CW'($urandom_range(0, (1 << CW) - 1)));
      send_cmd(OP_LOAD, pick_coord(cx, spread), pick_coord(cy, spread));
    end
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(99) < 15)
        send_cmd(OP_LOAD, pick_coord(cx, spread), pick_coord(cy, spread));
      if ($urandom_range(99) < 4)
        send_cmd(OP_REPORT, pick_coord(cx, spread), pick_coord(cy, spread));
      send_cmd(OP_PROBE, pick_coord(cx, spread), pick_coord(cy, spread));
    end
    send_cmd(OP_REPORT, CW'($urandom_range(0, (1 << CW) - 1)),
             CW'($urandom_range(0, (1 << CW) - 1)));
    if ($urandom_range(99) < 8)
      send_cmd(OP_REPORT, '0, '0);
  endtask

  initial begin
    logic [TOL_W-1:0] tol_setting;
    tracker = new();

    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.op      <= OP_LOAD;
    cmd_ch.coord_x <= '0;
    cmd_ch.coord_y <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed, at the reset tolerance of 30.
    send_cmd(OP_REPORT, '0, '0);                 // nothing compared yet
    send_cmd(OP_PROBE, 10'd5, 10'd5);            // probe into an empty store
    send_cmd(OP_IGNORED, '1, '1);                // unused op
    send_cmd(OP_LOAD, '0, '0);
    send_cmd(OP_LOAD, '1, '1);
    send_cmd(OP_LOAD, '1, '0);
    send_cmd(OP_PROBE, '0, '1);                  // equal distance to 0 and 1: lower index
    send_cmd(OP_REPORT, '0, '0);
    send_cmd(OP_LOAD, 10'd512, 10'd512);
    send_cmd(OP_LOAD, 10'd515, 10'd516);
    send_cmd(OP_PROBE, 10'd512, 10'd512);        // zero distance at index 0
    send_cmd(OP_PROBE, 10'd515, 10'd516);        // zero again later: earlier probe kept
    send_cmd(OP_REPORT, '0, '0);
    send_cmd(OP_LOAD, 10'd100, 10'd100);
    send_cmd(OP_PROBE, 10'd130, 10'd100);        // exactly at tolerance: not a neighbour
    send_cmd(OP_REPORT, '0, '0);
    send_cmd(OP_LOAD, 10'd100, 10'd100);
    send_cmd(OP_IGNORED, 10'd682, 10'd341);
    send_cmd(OP_PROBE, 10'd129, 10'd100);        // just inside tolerance
    send_cmd(OP_REPORT, '0, '0);
    wait_idle();

    // Random scenes in groups, each group at its own tolerance; the zero and
    // full-scale settings come first, group three runs with no idling.
    for (int grp = 0; grp < 6; grp++) begin
      case (grp)
        0:       tol_setting = '0;
        1:       tol_setting = '1;
        3:       tol_setting = 10'd1;
        5:       tol_setting = 10'd512;
        default: tol_setting = TOL_W'($urandom_range(0, (1 << TOL_W) - 1));
      endcase
      write_tolerance(tol_setting);
      calm = (grp == 3);
      repeat (7) run_session(($urandom_range(99) < 10) ? 40 : 12);
      wait_idle();
    end
    calm = 1'b0;

    if (tracker.mismatches == 0)
      $display("closest_point_pair_distance verification clean");
    else
      $display("closest_point_pair_distance verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/cpd_pkg.sv
sv/cpd_if.sv
sv/closest_point_pair_distance.sv
sv/cpd_checker.sv
tb/closest_point_pair_distance_tb.sv
